[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;

   localparam int WIDTH = 16;
   localparam int MW    = 2 * WIDTH;
   localparam int NW    = MW + 1;
   localparam int CW    = $clog2(NW);
   localparam int KW    = $clog2(NW + 1);
   localparam int NUM_W = 33;
   localparam int DEN_W = 32;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] SEL_P1 = 2'd0;
   localparam logic [1:0] SEL_P2 = 2'd1;
   localparam logic [1:0] SEL_PD = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [WIDTH-1:0] a_num;
      logic signed [WIDTH-1:0] a_den;
      logic signed [WIDTH-1:0] b_num;
      logic signed [WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] res_num;
      logic signed [DEN_W-1:0] res_den;
      logic                    zero_divisor;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic [1:0] mul_sel;
      logic       add;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic gcd_done;
   } status_type;

endpackage

[rtl/rau_datapath.sv]
`timescale 1ns / 1ps
module rau_datapath (
   input  logic             clock,
   input  rau_pkg::req_type    req_data,
   input  rau_pkg::cmd_type    cmd,
   output rau_pkg::status_type status,
   output rau_pkg::rsp_type    rsp_data
);
   import rau_pkg::*;

   logic [1:0]       op_ff, op_in;
   logic             an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic             an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [WIDTH-1:0] an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic [WIDTH-1:0] an_mag_in, ad_mag_in, bn_mag_in, bd_mag_in;
   logic [MW-1:0]    p1_ff, p2_ff, pd_ff, p1_in, p2_in, pd_in;
   logic [NW-1:0]    nmag_ff, dmag_ff, nmag_in, dmag_in;
   logic             nneg_ff, dneg_ff, zdiv_ff, nneg_in, dneg_in, zdiv_in;
   logic [NW-1:0]    x_ff, y_ff, x_in, y_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [NW-1:0]    g_ff, g_in;
   logic [NW-1:0]    qn_ff, qd_ff, rn_ff, rd_ff, qn_in, qd_in, rn_in, rd_in;

   logic [WIDTH-1:0] ma, mb;
   logic [MW-1:0]    prod;
   logic             s1, s2;
   logic [NW-1:0]    e1, e2;
   logic [NW:0]      rns, rds;
   logic             gen, ged;
   logic signed [NW:0] sn, sd;

   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] x);
      mag_of = x[WIDTH-1] ? (~x + WIDTH'(1)) : x;
   endfunction

   always_comb begin
      op_in     = op_ff;
      an_neg_in = an_neg_ff;
      ad_neg_in = ad_neg_ff;
      bn_neg_in = bn_neg_ff;
      bd_neg_in = bd_neg_ff;
      an_mag_in = an_mag_ff;
      ad_mag_in = ad_mag_ff;
      bn_mag_in = bn_mag_ff;
      bd_mag_in = bd_mag_ff;
      if (cmd.load) begin
         op_in     = req_data.op;
         an_mag_in = mag_of(req_data.a_num);
         an_neg_in = req_data.a_num[WIDTH-1];
         bn_mag_in = mag_of(req_data.b_num);
         bn_neg_in = req_data.b_num[WIDTH-1];
         if (req_data.op == OP_SUB) begin
            bn_neg_in = (req_data.b_num != '0) && !req_data.b_num[WIDTH-1];
         end
         ad_mag_in = mag_of(req_data.a_den);
         ad_neg_in = req_data.a_den[WIDTH-1];
         if (req_data.a_den == '0) begin
            ad_mag_in = WIDTH'(1);
            ad_neg_in = 1'b0;
         end
         bd_mag_in = mag_of(req_data.b_den);
         bd_neg_in = req_data.b_den[WIDTH-1];
         if (req_data.b_den == '0) begin
            bd_mag_in = WIDTH'(1);
            bd_neg_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         SEL_P1: begin
            ma = an_mag_ff;
            mb = (op_ff == OP_MUL) ? bn_mag_ff : bd_mag_ff;
         end
         SEL_P2: begin
            ma = ad_mag_ff;
            mb = bn_mag_ff;
         end
         default: begin
            ma = ad_mag_ff;
            mb = (op_ff == OP_DIV) ? bn_mag_ff : bd_mag_ff;
         end
      endcase
      prod  = ma * mb;
      p1_in = p1_ff;
      p2_in = p2_ff;
      pd_in = pd_ff;
      if (cmd.mul) begin
         case (cmd.mul_sel)
            SEL_P1:  p1_in = prod;
            SEL_P2:  p2_in = prod;
            default: pd_in = prod;
         endcase
      end
   end

   always_comb begin
      s1      = an_neg_ff ^ ((op_ff == OP_MUL) ? bn_neg_ff : bd_neg_ff);
      s2      = ad_neg_ff ^ bn_neg_ff;
      e1      = NW'(p1_ff);
      e2      = NW'(p2_ff);
      nmag_in = nmag_ff;
      nneg_in = nneg_ff;
      dmag_in = dmag_ff;
      dneg_in = dneg_ff;
      zdiv_in = zdiv_ff;
      if (cmd.add) begin
         if (op_ff == OP_ADD || op_ff == OP_SUB) begin
            if (s1 == s2) begin
               nmag_in = e1 + e2;
               nneg_in = s1;
            end else if (e1 >= e2) begin
               nmag_in = e1 - e2;
               nneg_in = s1;
            end else begin
               nmag_in = e2 - e1;
               nneg_in = s2;
            end
         end else begin
            nmag_in = e1;
            nneg_in = s1;
         end
         dmag_in = NW'(pd_ff);
         dneg_in = ad_neg_ff ^ ((op_ff == OP_DIV) ? bn_neg_ff : bd_neg_ff);
         zdiv_in = 1'b0;
         if (op_ff == OP_DIV && pd_ff == '0) begin
            dmag_in = NW'(1);
            dneg_in = 1'b0;
            zdiv_in = 1'b1;
         end
         if (nmag_in == '0) begin
            nneg_in = 1'b0;
            dmag_in = NW'(1);
            dneg_in = 1'b0;
         end
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      if (cmd.gcd_init) begin
         x_in = nmag_ff;
         y_in = dmag_ff;
         k_in = '0;
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
   end

   always_comb begin
      rns   = {rn_ff, qn_ff[NW-1]};
      rds   = {rd_ff, qd_ff[NW-1]};
      gen   = rns >= {1'b0, g_ff};
      ged   = rds >= {1'b0, g_ff};
      g_in  = g_ff;
      qn_in = qn_ff;
      qd_in = qd_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      if (cmd.div_init) begin
         g_in  = (nmag_ff == '0) ? NW'(1) : (x_ff << k_ff);
         qn_in = nmag_ff;
         qd_in = dmag_ff;
         rn_in = '0;
         rd_in = '0;
      end else if (cmd.div_step) begin
         qn_in = {qn_ff[NW-2:0], gen};
         qd_in = {qd_ff[NW-2:0], ged};
         rn_in = gen ? NW'(rns - {1'b0, g_ff}) : NW'(rns);
         rd_in = ged ? NW'(rds - {1'b0, g_ff}) : NW'(rds);
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      an_neg_ff <= an_neg_in;
      ad_neg_ff <= ad_neg_in;
      bn_neg_ff <= bn_neg_in;
      bd_neg_ff <= bd_neg_in;
      an_mag_ff <= an_mag_in;
      ad_mag_ff <= ad_mag_in;
      bn_mag_ff <= bn_mag_in;
      bd_mag_ff <= bd_mag_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      pd_ff     <= pd_in;
      nmag_ff   <= nmag_in;
      dmag_ff   <= dmag_in;
      nneg_ff   <= nneg_in;
      dneg_ff   <= dneg_in;
      zdiv_ff   <= zdiv_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      qn_ff     <= qn_in;
      qd_ff     <= qd_in;
      rn_ff     <= rn_in;
      rd_ff     <= rd_in;
   end

   always_comb begin
      sn = nneg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});
      sd = dneg_ff ? -$signed({1'b0, qd_ff}) : $signed({1'b0, qd_ff});
      rsp_data.res_num      = NUM_W'(sn);
      rsp_data.res_den      = DEN_W'(sd);
      rsp_data.zero_divisor = zdiv_ff;
      status.n_zero         = (nmag_ff == '0);
      status.gcd_done       = (x_ff == y_ff);
   end

endmodule

[rtl/rau_control.sv]
`timescale 1ns / 1ps
module rau_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rau_pkg::status_type status,
   output rau_pkg::cmd_type    cmd
);
   import rau_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL0 = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_GINI = 3'd5;
   localparam logic [2:0] S_GCD  = 3'd6;
   localparam logic [2:0] S_DIV  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic          out_ff, out_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      out_in   = out_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = SEL_P1;
      req_ready = !out_ff && (state_ff == S_IDLE);
      rsp_valid = out_ff;
      if (out_ff) begin
         if (rsp_ready) begin
            out_in = 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_MUL0;
               end
            end
            S_MUL0: begin
               cmd.mul = 1'b1;
               cmd.mul_sel = SEL_P1;
               state_in = S_MUL1;
            end
            S_MUL1: begin
               cmd.mul = 1'b1;
               cmd.mul_sel = SEL_P2;
               state_in = S_MUL2;
            end
            S_MUL2: begin
               cmd.mul = 1'b1;
               cmd.mul_sel = SEL_PD;
               state_in = S_ADD;
            end
            S_ADD: begin
               cmd.add = 1'b1;
               state_in = S_GINI;
            end
            S_GINI: begin
               if (status.n_zero) begin
                  cmd.div_init = 1'b1;
                  cnt_in = '0;
                  state_in = S_DIV;
               end else begin
                  cmd.gcd_init = 1'b1;
                  state_in = S_GCD;
               end
            end
            S_GCD: begin
               if (status.gcd_done) begin
                  cmd.div_init = 1'b1;
                  cnt_in = '0;
                  state_in = S_DIV;
               end else begin
                  cmd.gcd_step = 1'b1;
               end
            end
            S_DIV: begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(NW - 1)) begin
                  state_in = S_IDLE;
                  out_in = 1'b1;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/rational_arithmetic_unit.sv]
// channel | ports                          | payload
// req     | req_valid, req_ready, req_data | op, a_num, a_den, b_num, b_den
// rsp     | rsp_valid, rsp_ready, rsp_data | res_num, res_den, zero_divisor
// One beat at a time: 3 multiplies on one shared 16x16 multiplier, one add,
// a binary gcd, then 33 restoring-division steps for both terms.
// Synchronous active-high reset clears the controller only.
// A result holds on rsp_data until taken; req_ready stays low meanwhile.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   cmd_type    cmd;
   status_type status;

   rau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rau_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.res_den != '0) else $error("zero denominator");
   a_zdiv_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_divisor) |-> rsp_data.res_den == DEN_W'(1))
      else $error("zero divisor without unit denominator");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import rau_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      recv_hold = 1'b0;
   int      error_count = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   int      zdiv_seen = 0;
   int      quiet_cycles = 0;

   rational_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rsp_type reduce_fraction(req_type r);
      rsp_type o;
      longint an, ad, bn, bd, n, d;
      longint unsigned nm, dm, g;
      an = r.a_num;
      ad = (r.a_den == 0) ? 1 : r.a_den;
      bn = r.b_num;
      bd = (r.b_den == 0) ? 1 : r.b_den;
      o.zero_divisor = 1'b0;
      case (r.op)
         OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
         OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         default: begin
            n = an * bd;
            d = ad * bn;
            if (d == 0) begin
               d = 1;
               o.zero_divisor = 1'b1;
            end
         end
      endcase
      if (n == 0) begin
         d = 1;
      end else begin
         nm = (n < 0) ? -n : n;
         dm = (d < 0) ? -d : d;
         g = gcd_of(nm, dm);
         n = n / longint'(g);
         d = d / longint'(g);
      end
      o.res_num = n[NUM_W-1:0];
      o.res_den = d[DEN_W-1:0];
      return o;
   endfunction

   task automatic send_beat(req_type r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(reduce_fraction(r));
      beats_sent++;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(0);
         3: return 16'($signed($urandom_range(16)) - 8);
         4: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.op = 2'($urandom_range(3));
      r.a_num = pick_value();
      r.a_den = pick_value();
      r.b_num = pick_value();
      r.b_den = pick_value();
      return r;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] vals[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
      req_type r;
      for (int op = 0; op < 4; op++) begin
         for (int i = 0; i < 5; i++) begin
            r.op = 2'(op);
            r.a_num = vals[i];
            r.a_den = vals[(i + 1) % 5];
            r.b_num = vals[(i + 2) % 5];
            r.b_den = vals[(i + 3) % 5];
            send_beat(r);
         end
      end
      send_beat('{OP_DIV, 16'sd3, 16'sd0, 16'sd0, 16'sd0});
      send_beat('{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2});
      send_beat('{OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      wait_drained();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) send_beat(random_req());
   endtask

   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            recv_hold = 1'b0;
         end
         repeat (6) send_beat(random_req());
      join
      wait_drained();
      repeat (20) send_beat(random_req());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_hold && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            beats_checked++;
            if (e.zero_divisor) zdiv_seen++;
            if (rsp_data.res_num !== e.res_num) begin
               $error("res_num expected %0d actual %0d", e.res_num, rsp_data.res_num);
               error_count++;
            end
            if (rsp_data.res_den !== e.res_den) begin
               $error("res_den expected %0d actual %0d", e.res_den, rsp_data.res_den);
               error_count++;
            end
            if (rsp_data.zero_divisor !== e.zero_divisor) begin
               $error("zero_divisor expected %0b actual %0b", e.zero_divisor,
                  rsp_data.zero_divisor);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 250);
      test_random_phase(68, 0, 250);
      test_random_phase(0, 68, 250);
      test_random_phase(28, 28, 250);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d beats over all ops, extremes and idle/stall mixes", beats_sent);
      $display("checked %0d results, %0d with zero divisor", beats_checked, zdiv_seen);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
